// File: rtl/core/ttlc_pkg.sv
// ----------------------------------------------------------------------------
// ttlc_pkg
// Shared types, codes and defaults of the TTL cache directory.
// ----------------------------------------------------------------------------
package ttlc_pkg;

  localparam int DEF_ENTRIES   = 64;
  localparam int DEF_TIME_BITS = 48;

  localparam logic [39:0] BUDGET_RST = 40'd268435456;
  localparam logic [31:0] DTTL_RST   = 32'd60000;

  typedef enum logic [1:0] {
    FN_PUT = 2'd0,
    FN_GET = 2'd1,
    FN_INV = 2'd2,
    FN_NOP = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CFG_POLICY = 2'd0,
    CFG_BUDGET = 2'd1,
    CFG_DTTL   = 2'd2,
    CFG_NONE   = 2'd3
  } cfg_idx_t;

  localparam logic [1:0] POL_LFU = 2'd1;
  localparam logic [1:0] POL_EXP = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_EXPIRED  = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_OVER     = 3'd5;
  localparam logic [2:0] ST_INV_ABS  = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key_id;
    logic [47:0] now_ms;
    logic [31:0] obj_size;
    logic [31:0] ttl_req;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] hit_size;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [39:0] bytes_in_use;
    logic [6:0]  entries_in_use;
  } out_rsp_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_START,
    OP_RD,
    OP_FIND_NEXT,
    OP_VIC_EV,
    OP_CMP_EXP,
    OP_CMP_VIC,
    OP_CMP_CUR,
    OP_CMP_EV,
    OP_CMP_END,
    OP_HIT,
    OP_APPEND,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic       st_we;
    logic [2:0] st;
    logic       miss_inc;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       size_zero;
    logic       full;
    logic       idx_end;
    logic       key_match;
    logic       expired;
    logic       over_budget;
    logic       policy_exp;
    logic       freed;
    logic       fill_zero;
    logic       out_free;
  } stat_t;

endpackage

// File: rtl/core/ttlc_dp.sv
// ----------------------------------------------------------------------------
// ttlc_dp
// Datapath: record memory, scan pointers, counters, config and output register.
// ----------------------------------------------------------------------------
module ttlc_dp import ttlc_pkg::*; #(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_req_t     in_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data,
  input  cmd_t        cmd,
  output stat_t       stat,
  output out_rsp_t    out_data,
  output logic        out_valid,
  input  logic        out_ready
);

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int TB = TIME_BITS;

  logic [31:0]  mem_key     [ENTRIES];
  logic [31:0]  mem_size    [ENTRIES];
  logic [31:0]  mem_life    [ENTRIES];
  logic [TB-1:0] mem_created [ENTRIES];
  logic [TB-1:0] mem_touched [ENTRIES];
  logic [31:0]  mem_uses    [ENTRIES];

  logic [31:0]   rd_key_r, rd_size_r, rd_life_r, rd_uses_r;
  logic [TB-1:0] rd_created_r, rd_touched_r;

  logic [1:0]  policy_r;
  logic [39:0] budget_r;
  logic [31:0] dttl_r;
  in_req_t     req_r;

  logic [AW:0]   fill_r, fill_nxt, idx_r, idx_nxt, wr_r, wr_nxt;
  logic [AW-1:0] tgt_r, tgt_nxt, vic_r, vic_nxt;
  logic [63:0]   best_r, best_nxt;
  logic          mode_exp_r, mode_exp_nxt, freed_r, freed_nxt;
  logic [39:0]   bytes_r, bytes_nxt;
  logic [31:0]   hits_r, hits_nxt, misses_r, misses_nxt, hsize_r, hsize_nxt;
  logic [2:0]    status_r, status_nxt;
  out_rsp_t      out_r, out_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          mem_we, rd_en;
  logic [AW-1:0] wa;
  logic [31:0]   w_key, w_size, w_life, w_uses;
  logic [TB-1:0] w_created, w_touched;

  logic [63:0]   now64, life64, vval;
  logic [TB-1:0] now_t, life_t, age, dlife_t;
  logic [63:0]   rtl64;
  logic          expired, drop;
  logic [40:0]   sum;
  logic [15:0]   fill16;
  logic [31:0]   ttl_sel;

  assign now64  = {16'b0, req_r.now_ms};
  assign now_t  = now64[TB-1:0];
  assign life64 = {32'b0, rd_life_r};
  assign life_t = life64[TB-1:0];
  assign age    = now_t - rd_created_r;
  assign expired = age > life_t;
  assign vval   = (policy_r == POL_LFU) ? 64'(rd_uses_r) : 64'(rd_touched_r);
  assign sum    = {1'b0, bytes_r} + {9'b0, req_r.obj_size};
  assign drop   = mode_exp_r ? expired : (idx_r[AW-1:0] == tgt_r);
  assign fill16 = 16'(fill_r);
  assign ttl_sel = (req_r.ttl_req == 32'd0) ? dttl_r : req_r.ttl_req;
  assign rtl64  = {32'b0, ttl_sel};
  assign dlife_t = rtl64[TB-1:0];

  always_comb begin
    stat.func        = req_r.func;
    stat.size_zero   = (req_r.obj_size == 32'd0);
    stat.full        = (fill_r >= (AW+1)'(ENTRIES));
    stat.idx_end     = (idx_r >= fill_r);
    stat.key_match   = (rd_key_r == req_r.key_id);
    stat.expired     = expired;
    stat.over_budget = (sum > {1'b0, budget_r});
    stat.policy_exp  = (policy_r == POL_EXP);
    stat.freed       = freed_r;
    stat.fill_zero   = (fill_r == '0);
    stat.out_free    = !out_valid_r || out_ready;
  end

  always_comb begin
    fill_nxt = fill_r; idx_nxt = idx_r; wr_nxt = wr_r; tgt_nxt = tgt_r;
    vic_nxt = vic_r; best_nxt = best_r; mode_exp_nxt = mode_exp_r;
    freed_nxt = freed_r; bytes_nxt = bytes_r; hits_nxt = hits_r;
    misses_nxt = misses_r; hsize_nxt = hsize_r; status_nxt = status_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we = 1'b0; rd_en = 1'b0; wa = wr_r[AW-1:0];
    w_key = rd_key_r; w_size = rd_size_r; w_life = rd_life_r; w_uses = rd_uses_r;
    w_created = rd_created_r; w_touched = rd_touched_r;
    case (cmd.op)
      OP_LATCH: begin
        status_nxt = ST_OK;
        hsize_nxt  = 32'd0;
      end
      OP_SCAN_START: begin
        idx_nxt  = '0;
        best_nxt = '1;
        vic_nxt  = '0;
      end
      OP_RD: rd_en = 1'b1;
      OP_FIND_NEXT: idx_nxt = idx_r + 1'b1;
      OP_VIC_EV: begin
        if (vval < best_r) begin
          best_nxt = vval;
          vic_nxt  = idx_r[AW-1:0];
        end
        idx_nxt = idx_r + 1'b1;
      end
      OP_CMP_EXP: begin
        idx_nxt = '0; wr_nxt = '0; mode_exp_nxt = 1'b1; freed_nxt = 1'b0;
      end
      OP_CMP_VIC: begin
        idx_nxt = {1'b0, vic_r}; wr_nxt = {1'b0, vic_r}; tgt_nxt = vic_r;
        mode_exp_nxt = 1'b0; freed_nxt = 1'b0;
      end
      OP_CMP_CUR: begin
        wr_nxt = idx_r; tgt_nxt = idx_r[AW-1:0];
        mode_exp_nxt = 1'b0; freed_nxt = 1'b0;
      end
      OP_CMP_EV: begin
        if (drop) begin
          freed_nxt = 1'b1;
          if (bytes_r >= {8'b0, rd_size_r}) bytes_nxt = bytes_r - {8'b0, rd_size_r};
        end else begin
          mem_we = 1'b1;
          wr_nxt = wr_r + 1'b1;
        end
        idx_nxt = idx_r + 1'b1;
      end
      OP_CMP_END: fill_nxt = wr_r;
      OP_HIT: begin
        mem_we    = 1'b1;
        wa        = idx_r[AW-1:0];
        w_touched = now_t;
        w_uses    = rd_uses_r + 32'd1;
        hsize_nxt = rd_size_r;
        hits_nxt  = hits_r + 32'd1;
      end
      OP_APPEND: begin
        mem_we    = 1'b1;
        wa        = fill_r[AW-1:0];
        w_key     = req_r.key_id;
        w_size    = req_r.obj_size;
        w_life    = dlife_t[31:0];
        w_created = now_t;
        w_touched = now_t;
        w_uses    = 32'd0;
        bytes_nxt = sum[39:0];
        fill_nxt  = fill_r + 1'b1;
      end
      OP_OUT: begin
        out_nxt.status         = status_r;
        out_nxt.hit_size       = hsize_r;
        out_nxt.hits           = hits_r;
        out_nxt.misses         = misses_r;
        out_nxt.bytes_in_use   = bytes_r;
        out_nxt.entries_in_use = fill16[6:0];
        out_valid_nxt = 1'b1;
      end
      default: ;
    endcase
    if (cmd.st_we) status_nxt = cmd.st;
    if (cmd.miss_inc) misses_nxt = misses_r + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_key[wa]     <= w_key;
      mem_size[wa]    <= w_size;
      mem_life[wa]    <= w_life;
      mem_created[wa] <= w_created;
      mem_touched[wa] <= w_touched;
      mem_uses[wa]    <= w_uses;
    end
    if (rd_en) begin
      rd_key_r     <= mem_key[idx_r[AW-1:0]];
      rd_size_r    <= mem_size[idx_r[AW-1:0]];
      rd_life_r    <= mem_life[idx_r[AW-1:0]];
      rd_created_r <= mem_created[idx_r[AW-1:0]];
      rd_touched_r <= mem_touched[idx_r[AW-1:0]];
      rd_uses_r    <= mem_uses[idx_r[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= 2'd0;
      budget_r    <= BUDGET_RST;
      dttl_r      <= DTTL_RST;
      fill_r      <= '0;
      bytes_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_POLICY: policy_r <= cfg_data[1:0];
          CFG_BUDGET: budget_r <= cfg_data;
          CFG_DTTL:   dttl_r   <= cfg_data[31:0];
          default: ;
        endcase
      end
      fill_r      <= fill_nxt;
      bytes_r     <= bytes_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LATCH) req_r <= in_data;
    idx_r      <= idx_nxt;
    wr_r       <= wr_nxt;
    tgt_r      <= tgt_nxt;
    vic_r      <= vic_nxt;
    best_r     <= best_nxt;
    mode_exp_r <= mode_exp_nxt;
    freed_r    <= freed_nxt;
    hsize_r    <= hsize_nxt;
    status_r   <= status_nxt;
    out_r      <= out_nxt;
  end

  assign out_data  = out_r;
  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/ttlc_ctrl.sv
// ----------------------------------------------------------------------------
// ttlc_ctrl
// Request sequencer: lookup, victim scan, compaction and put flow.
// ----------------------------------------------------------------------------
module ttlc_ctrl import ttlc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE     = 12'b000000000001,
    S_DISPATCH = 12'b000000000010,
    S_FIND_RD  = 12'b000000000100,
    S_FIND_EV  = 12'b000000001000,
    S_EVICT    = 12'b000000010000,
    S_VIC_RD   = 12'b000000100000,
    S_VIC_EV   = 12'b000001000000,
    S_CMP_RD   = 12'b000010000000,
    S_CMP_EV   = 12'b000100000000,
    S_AFTER_EV = 12'b001000000000,
    S_BUDGET   = 12'b010000000000,
    S_DONE     = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ctx_ev_r, ctx_ev_nxt;     // compaction belongs to an eviction
  logic   ph_full_r, ph_full_nxt;   // eviction forced by a full table

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    ctx_ev_nxt  = ctx_ev_r;
    ph_full_nxt = ph_full_r;
    cmd = '{op: OP_NONE, st_we: 1'b0, st: ST_OK, miss_inc: 1'b0};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (func_t'(stat.func))
          FN_PUT: begin
            if (stat.size_zero) begin
              cmd.st_we = 1'b1; cmd.st = ST_BAD_SIZE;
              state_nxt = S_DONE;
            end else if (stat.full) begin
              ph_full_nxt = 1'b1;
              state_nxt   = S_EVICT;
            end else begin
              state_nxt = S_BUDGET;
            end
          end
          FN_GET, FN_INV: begin
            cmd.op    = OP_SCAN_START;
            state_nxt = S_FIND_RD;
          end
          default: state_nxt = S_DONE;
        endcase
      end
      S_FIND_RD: begin
        if (stat.idx_end) begin
          cmd.st_we = 1'b1;
          if (stat.func == FN_GET) begin
            cmd.st = ST_MISS; cmd.miss_inc = 1'b1;
          end else begin
            cmd.st = ST_INV_ABS;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_FIND_EV;
        end
      end
      S_FIND_EV: begin
        if (!stat.key_match) begin
          cmd.op    = OP_FIND_NEXT;
          state_nxt = S_FIND_RD;
        end else if (stat.func == FN_GET && !stat.expired) begin
          cmd.op    = OP_HIT;
          state_nxt = S_DONE;
        end else begin
          if (stat.func == FN_GET) begin
            cmd.st_we = 1'b1; cmd.st = ST_EXPIRED; cmd.miss_inc = 1'b1;
          end
          cmd.op     = OP_CMP_CUR;
          ctx_ev_nxt = 1'b0;
          state_nxt  = S_CMP_RD;
        end
      end
      S_EVICT: begin
        ctx_ev_nxt = 1'b1;
        if (stat.policy_exp) begin
          cmd.op    = OP_CMP_EXP;
          state_nxt = S_CMP_RD;
        end else begin
          cmd.op    = OP_SCAN_START;
          state_nxt = S_VIC_RD;
        end
      end
      S_VIC_RD: begin
        if (stat.idx_end) begin
          cmd.op    = OP_CMP_VIC;
          state_nxt = S_CMP_RD;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_VIC_EV;
        end
      end
      S_VIC_EV: begin
        cmd.op    = OP_VIC_EV;
        state_nxt = S_VIC_RD;
      end
      S_CMP_RD: begin
        if (stat.idx_end) begin
          cmd.op    = OP_CMP_END;
          state_nxt = ctx_ev_r ? S_AFTER_EV : S_DONE;
        end else begin
          cmd.op    = OP_RD;
          state_nxt = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        cmd.op    = OP_CMP_EV;
        state_nxt = S_CMP_RD;
      end
      S_AFTER_EV: begin
        if (ph_full_r && stat.full) begin
          cmd.st_we = 1'b1; cmd.st = ST_FULL;
          state_nxt = S_DONE;
        end else if (!ph_full_r && !stat.freed) begin
          cmd.st_we = 1'b1; cmd.st = ST_OVER;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_BUDGET;
        end
        ph_full_nxt = 1'b0;
      end
      S_BUDGET: begin
        if (!stat.fill_zero && stat.over_budget) begin
          ph_full_nxt = 1'b0;
          state_nxt   = S_EVICT;
        end else begin
          cmd.op    = OP_APPEND;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ctx_ev_r  <= 1'b0;
      ph_full_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ctx_ev_r  <= ctx_ev_nxt;
      ph_full_r <= ph_full_nxt;
    end
  end

endmodule

// File: rtl/core/ttl_cache_with_lru_lfu_eviction.sv
// ----------------------------------------------------------------------------
// ttl_cache_with_lru_lfu_eviction
// Cache directory with TTL expiry and LRU, LFU or all-expired eviction.
// ----------------------------------------------------------------------------
// One request at a time: put, get or invalidate on a 32-bit key. Records are
// kept packed in insertion order in a single-port-write, registered-read
// memory, so every walk reads each record it visits into a register before
// it evaluates it. A get or invalidate scans from index 0 until a match or
// the end of the held records; a removal then compacts the records behind
// the match to close the gap. Each LRU/LFU eviction adds a victim scan over
// all held records and a compaction, an all-expired eviction one compaction
// pass. A finished response sits in the output register and the next
// request is accepted while it waits. Config writes are taken every cycle;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module ttl_cache_with_lru_lfu_eviction import ttlc_pkg::*; #(
  parameter int ENTRIES   = DEF_ENTRIES,
  parameter int TIME_BITS = DEF_TIME_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_req_t     in_data,
  // response channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_rsp_t    out_data,
  // config write channel: 0 policy, 1 byte budget, 2 default ttl
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  ttlc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ttlc_dp #(
    .ENTRIES   (ENTRIES),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule

// File: rtl/core/ttlc_checker.sv
// ----------------------------------------------------------------------------
// ttlc_checker
// Port-level checks of the cache directory, bound to the top level.
// ----------------------------------------------------------------------------
module ttlc_checker import ttlc_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("response dropped or changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_data.entries_in_use) <= 32'(ENTRIES))
    else $error("entry count above table depth");

  a_hsize: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.hit_size == 32'd0)
    else $error("hit size on a non-hit response");

endmodule

bind ttl_cache_with_lru_lfu_eviction ttlc_checker #(.ENTRIES(ENTRIES)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
